/* rtl/core/mfpr_pkg.sv */
// Shared types and constants for the marker framed packet receiver.
// Used by the frame store and the top level; depends on nothing else.
package mfpr_pkg;

  // Default frame store depth in bytes
  localparam int BUFFER_SIZE_DEF = 64;

  // Fixed field widths
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 16;
  localparam int INDEX_W = 6;

  // Saturation value of the byte counter
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_OPEN_MARK  = 1'b0,
    REG_CLOSE_MARK = 1'b1
  } cfg_reg_t;

  // Control states, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

endpackage

/* rtl/core/mfpr_store.sv */
// Frame store of the marker framed packet receiver: one write port and one
// read port with registered read data. Depends on mfpr_pkg.
module mfpr_store
  import mfpr_pkg::*;
#(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEF,
  localparam int IDX_W = (BUFFER_SIZE > 1) ? $clog2(BUFFER_SIZE) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [BUFFER_SIZE];

  // Write a frame byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/marker_framed_packet_receiver.sv */
// Marker framed packet receiver: top level.
// Depends on mfpr_pkg and mfpr_store.
//
// Input channel: one received byte per word on rx_byte, handshake in_valid /
// in_stall. Outside a frame, bytes are dropped until the start marker opens a
// frame. Inside a frame each byte other than the end marker goes into the
// frame store, the first one also sets declared_length. The byte taken at
// the end marker closes the frame.
// Output channel: out_valid / out_stall. An accepted frame comes out as one
// word per stored byte (slot 0 up), last marking the final one; an accepted
// empty frame or a rejected frame gives a single word with last set.
// Throughput: one input byte per cycle while no result is waiting. A rejected or
// empty frame's word appears in the cycle after the end marker is taken; a run's
// first word passes the store read and output registers, then one word per cycle
// while not stalled; input stalls until the final word is in the output register.
// Configuration: cfg_write, cfg_index, cfg_data set the start and end markers;
// write only while the block is idle.
// Reset (rst, synchronous): markers return to 60 and 62, the frame and its
// counters clear, the output register empties. Store contents are not cleared.
// A stalled output holds its word; the run and the input wait behind it.
module marker_framed_packet_receiver
  import mfpr_pkg::*;
#(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [BYTE_W-1:0]  cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  rx_byte,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               frame_ok,
  output logic               byte_valid,
  output logic [BYTE_W-1:0]  data_byte,
  output logic [INDEX_W-1:0] byte_index,
  output logic [COUNT_W-1:0] received_count,
  output logic [BYTE_W-1:0]  declared_length,
  output logic               last
);

  localparam int IDX_W = (BUFFER_SIZE > 1) ? $clog2(BUFFER_SIZE) : 1;
  localparam logic [IDX_W-1:0]   IDX_TOP   = IDX_W'(BUFFER_SIZE - 1);
  localparam logic [COUNT_W-1:0] COUNT_BUF = COUNT_W'(BUFFER_SIZE);

  // Configuration registers
  logic [BYTE_W-1:0] open_mark;
  logic [BYTE_W-1:0] close_mark;

  // Frame state
  state_t             state;
  logic               in_frame;
  logic [IDX_W-1:0]   write_index;
  logic [COUNT_W-1:0] byte_counter;
  logic [BYTE_W-1:0]  length_byte;

  // Run state
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   run_last;
  logic [COUNT_W-1:0] run_count;

  // Store ports
  logic              wr_en;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;

  // Decoded events
  logic in_take;
  logic out_free;
  logic is_end;
  logic is_data;
  logic is_close;
  logic close_ok;
  logic close_empty;
  logic emit_load;
  logic [IDX_W-1:0]   write_index_next;
  logic [IDX_W-1:0]   run_last_next;
  logic [IDX_W+INDEX_W-1:0] index_ext;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign in_take  = in_valid && !in_stall;

  assign is_end   = in_frame && (rx_byte == close_mark);
  assign is_data  = in_take && in_frame && !is_end;
  assign is_close = in_take && is_end;

  assign close_ok    = (byte_counter == COUNT_W'(1)) ||
                       (byte_counter == COUNT_W'(length_byte));
  assign close_empty = (byte_counter == '0);

  // Clamp the write slot at the top of the store
  assign write_index_next = (write_index == IDX_TOP) ? write_index : write_index + 1'b1;

  // Final slot of the run
  assign run_last_next = (byte_counter >= COUNT_BUF) ? IDX_TOP
                                                    : IDX_W'(byte_counter - 1'b1);

  // Load a run word into the output register
  assign emit_load = (state == S_EMIT) && out_free;

  // Store access: write data bytes, read slot 0 on close, then step the run
  assign wr_en = is_data;
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (is_close && close_ok && !close_empty) begin
      rd_en = 1'b1;
    end else if (emit_load && (rd_idx != run_last)) begin
      rd_en   = 1'b1;
      rd_addr = rd_idx + 1'b1;
    end
  end

  mfpr_store #(
    .BUFFER_SIZE(BUFFER_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_index),
    .wr_data (rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      open_mark  <= BYTE_W'(60);
      close_mark <= BYTE_W'(62);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OPEN_MARK:  open_mark  <= cfg_data;
        REG_CLOSE_MARK: close_mark <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame tracking: open, store, close
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      write_index  <= '0;
      byte_counter <= '0;
      length_byte  <= '0;
    end else if (in_take) begin
      if (!in_frame) begin
        in_frame <= (rx_byte == open_mark);
      end else if (is_end) begin
        in_frame     <= 1'b0;
        write_index  <= '0;
        byte_counter <= '0;
      end else begin
        write_index <= write_index_next;
        if (write_index == '0) begin
          length_byte <= rx_byte;
        end
        if (byte_counter != COUNT_MAX) begin
          byte_counter <= byte_counter + 1'b1;
        end
      end
    end
  end

  // Run sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (is_close && close_ok && !close_empty) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_load && (rd_idx == run_last)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Run position and frame figures
  always_ff @(posedge clk) begin
    if (is_close) begin
      rd_idx    <= '0;
      run_last  <= run_last_next;
      run_count <= byte_counter;
    end else if (rd_en) begin
      rd_idx <= rd_addr;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((is_close && (!close_ok || close_empty)) || emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  assign index_ext = {{INDEX_W{1'b0}}, rd_idx};
  always_ff @(posedge clk) begin
    if (is_close && (!close_ok || close_empty)) begin
      frame_ok        <= close_ok;
      byte_valid      <= 1'b0;
      data_byte       <= '0;
      byte_index      <= '0;
      received_count  <= byte_counter;
      declared_length <= length_byte;
      last            <= 1'b1;
    end else if (emit_load) begin
      frame_ok        <= 1'b1;
      byte_valid      <= 1'b1;
      data_byte       <= rd_data;
      byte_index      <= index_ext[INDEX_W-1:0];
      received_count  <= run_count;
      declared_length <= length_byte;
      last            <= (rd_idx == run_last);
    end
  end

endmodule

/* dv/tb_marker_framed_packet_receiver.sv */
// Self-checking testbench for marker_framed_packet_receiver.
// Feeds directed and random byte streams with random valid/stall pacing and checks every
// output word against typed words or an in-bench deframer model. Depends on mfpr_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_marker_framed_packet_receiver
  import mfpr_pkg::*;
;

  localparam int          DEPTH       = BUFFER_SIZE_DEF;
  localparam int          CYCLE_LIMIT = 200_000;
  localparam int          TAIL_CYCLES = 4;
  localparam logic [7:0]  DEF_START   = 8'h3C;
  localparam logic [7:0]  DEF_END     = 8'h3E;

  typedef struct packed {
    logic               frame_ok;
    logic               byte_valid;
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [COUNT_W-1:0] received_count;
    logic [BYTE_W-1:0]  declared_length;
    logic               last;
  } frame_word_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    frame_word_t w;
  } dir_row_t;

  localparam frame_word_t NO_WORD = '0;

  // Directed stream under reset markers; typed words where the answer is obvious
  localparam dir_row_t DIRECTED [22] = '{
    '{8'h00, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'h3C, 1'b0, NO_WORD},
    '{8'h3E, 1'b1, '{1'b1, 1'b0, 8'h00, 6'd0, 16'd0, 8'h00, 1'b1}},
    '{8'h3C, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'h3E, 1'b1, '{1'b1, 1'b1, 8'hFF, 6'd0, 16'd1, 8'hFF, 1'b1}},
    '{8'h3C, 1'b0, NO_WORD},
    '{8'h3E, 1'b1, '{1'b0, 1'b0, 8'h00, 6'd0, 16'd0, 8'hFF, 1'b1}},
    '{8'h3C, 1'b0, NO_WORD},
    '{8'h03, 1'b0, NO_WORD},
    '{8'h3C, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h3E, 1'b0, NO_WORD},
    '{8'h3C, 1'b0, NO_WORD},
    '{8'h05, 1'b0, NO_WORD},
    '{8'hAA, 1'b0, NO_WORD},
    '{8'h3E, 1'b1, '{1'b0, 1'b0, 8'h00, 6'd0, 16'd2, 8'h05, 1'b1}},
    '{8'h3C, 1'b0, NO_WORD},
    '{8'h02, 1'b0, NO_WORD},
    '{8'h55, 1'b0, NO_WORD},
    '{8'h3E, 1'b0, NO_WORD}
  };

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [0:0]         cfg_index;
  logic [BYTE_W-1:0]  cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [BYTE_W-1:0]  rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic               frame_ok;
  logic               byte_valid;
  logic [BYTE_W-1:0]  data_byte;
  logic [INDEX_W-1:0] byte_index;
  logic [COUNT_W-1:0] received_count;
  logic [BYTE_W-1:0]  declared_length;
  logic               last;

  marker_framed_packet_receiver dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_ok        (frame_ok),
    .byte_valid      (byte_valid),
    .data_byte       (data_byte),
    .byte_index      (byte_index),
    .received_count  (received_count),
    .declared_length (declared_length),
    .last            (last)
  );

  // Deframer model state and markers
  logic               pf_open;
  int                 pf_wr;
  logic [COUNT_W-1:0] pf_count;
  logic [BYTE_W-1:0]  pf_len;
  logic [BYTE_W-1:0]  pf_store [DEPTH];
  logic [BYTE_W-1:0]  mk_start;
  logic [BYTE_W-1:0]  mk_end;

  frame_word_t fresh_words [$];
  frame_word_t words_due [$];
  int          err_cnt;
  int          bytes_sent;
  int          cycles;
  int          hold_cnt;
  bit          tx_fast;
  bit          rx_fast;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the model by one byte; words it causes land in fresh_words
  function automatic void deframe_byte(input logic [7:0] b);
    int run;
    fresh_words.delete();
    if (!pf_open) begin
      if (b == mk_start) pf_open = 1'b1;
    end else if (b != mk_end) begin
      pf_store[pf_wr] = b;
      if (pf_wr == 0) pf_len = b;
      if (pf_wr < DEPTH - 1) pf_wr++;
      if (pf_count != COUNT_MAX) pf_count++;
    end else begin
      if (pf_count == 1 || pf_count == {8'h00, pf_len}) begin
        run = (pf_count > DEPTH) ? DEPTH : int'(pf_count);
        if (run == 0) begin
          fresh_words.push_back(frame_word_t'{1'b1, 1'b0, 8'h00, 6'd0, pf_count, pf_len, 1'b1});
        end else begin
          for (int i = 0; i < run; i++) begin
            fresh_words.push_back(frame_word_t'{1'b1, 1'b1, pf_store[i], INDEX_W'(i),
                                                pf_count, pf_len, (i == run - 1)});
          end
        end
      end else begin
        fresh_words.push_back(frame_word_t'{1'b0, 1'b0, 8'h00, 6'd0, pf_count, pf_len, 1'b1});
      end
      pf_open  = 1'b0;
      pf_wr    = 0;
      pf_count = '0;
    end
  endfunction

  function automatic void note_error(input string what, input frame_word_t want,
                                     input frame_word_t got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s at cycle %0d", what, cycles);
      $display("  want ok=%0d vld=%0d data=%h idx=%0d cnt=%0d len=%0d last=%0d",
               want.frame_ok, want.byte_valid, want.data_byte, want.byte_index,
               want.received_count, want.declared_length, want.last);
      $display("  got  ok=%0d vld=%0d data=%h idx=%0d cnt=%0d len=%0d last=%0d",
               got.frame_ok, got.byte_valid, got.data_byte, got.byte_index,
               got.received_count, got.declared_length, got.last);
    end
  endfunction

  // Send one byte after a random gap (none if tx_fast); queue the typed word or model words
  task automatic send_byte(input logic [7:0] b, input logic use_row, input frame_word_t row_word);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    if (use_row) words_due.push_back(row_word);
    else foreach (fresh_words[i]) words_due.push_back(fresh_words[i]);
    bytes_sent++;
  endtask

  // Hold input until every expected word is out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_markers(input logic [7:0] s, input logic [7:0] e);
    cfg_write <= 1'b1;
    cfg_index <= REG_OPEN_MARK;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= REG_CLOSE_MARK;
    cfg_data  <= e;
    @(posedge clk);
    cfg_write <= 1'b0;
    mk_start = s;
    mk_end   = e;
  endtask

  // Well-formed frame: close any open one, then start, length byte, body, end
  task automatic send_frame(input logic [7:0] len_byte, input int body);
    logic [7:0] d;
    if (pf_open) send_byte(mk_end, 1'b0, NO_WORD);
    send_byte(mk_start, 1'b0, NO_WORD);
    send_byte(len_byte, 1'b0, NO_WORD);
    for (int i = 0; i < body; i++) begin
      do d = 8'($urandom_range(0, 255)); while (d == mk_end);
      send_byte(d, 1'b0, NO_WORD);
    end
    send_byte(mk_end, 1'b0, NO_WORD);
  endtask

  // Mix of good frames, broken frames and line noise
  task automatic random_phase(input int quota);
    int first;
    int pick;
    int len;
    int n;
    first = bytes_sent;
    while (bytes_sent - first < quota) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        do len = (pick == 0) ? $urandom_range(65, 120) : $urandom_range(1, 12);
        while (8'(len) == mk_end);
        send_frame(8'(len), len - 1);
      end else if (pick < 17) begin
        send_byte(mk_start, 1'b0, NO_WORD);
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_WORD);
        send_byte(mk_end, 1'b0, NO_WORD);
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_WORD);
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
  endtask

  // Check each output word; after each one, raise out_stall at random unless rx_fast is set
  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{frame_ok, byte_valid, data_byte, byte_index, received_count,
                declared_length, last};
        if (words_due.size() == 0) begin
          note_error("unexpected word", NO_WORD, got);
        end else begin
          want = words_due.pop_front();
          if (got !== want) note_error("word mismatch", want, got);
        end
        hold_cnt = rx_fast ? 0 : $urandom_range(0, 7);
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end
      out_stall <= (hold_cnt != 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_marker_framed_packet_receiver: done, errors");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_OPEN_MARK;
    cfg_data   = '0;
    in_valid   = 1'b0;
    rx_byte    = '0;
    tx_fast    = 1'b0;
    rx_fast    = 1'b0;
    err_cnt    = 0;
    bytes_sent = 0;
    cycles     = 0;
    pf_open    = 1'b0;
    pf_wr      = 0;
    pf_count   = '0;
    pf_len     = '0;
    mk_start   = DEF_START;
    mk_end     = DEF_END;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed stream under reset markers
    foreach (DIRECTED[i]) send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].w);
    drain();

    // random phases over marker settings, extremes and equal markers included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_markers(8'h00, 8'hFF);
        end
        1: begin
          write_markers(8'hFF, 8'h00);
        end
        2: begin
          write_markers(8'hA5, 8'hA5);
        end
        3: begin
          write_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        default: begin
          write_markers(DEF_START, DEF_END);
        end
      endcase
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      random_phase(40);
      drain();
    end

    // frame longer than the store with a matching length byte
    tx_fast = 1'b1;
    rx_fast = 1'b0;
    send_frame(8'd66, 65);
    drain();

    if (err_cnt == 0 && words_due.size() == 0) begin
      $display("tb_marker_framed_packet_receiver: done, clean");
    end else begin
      $display("tb_marker_framed_packet_receiver: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/mfpr_pkg.sv
rtl/core/mfpr_store.sv
rtl/core/marker_framed_packet_receiver.sv
dv/tb_marker_framed_packet_receiver.sv
